@@ design/bdq_pkg.sv @@
// shared types and codes for the bounded deque with value delete
// no dependencies
package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0]        count;
  } out_word_t;

  // per-cycle command broadcast to every cell; pushes and pops already qualified by fill
  typedef struct packed {
    logic                      push_front;
    logic                      push_back;
    logic                      pop_front;
    logic                      pop_back;
    logic                      del;
    logic signed [VALUE_W-1:0] key;
  } cell_cmd_t;

endpackage

@@ design/bdq_cell.sv @@
// one storage cell of the deque row: value, occupancy, shift and match
// depends on bdq_pkg
module bdq_cell
  import bdq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cell_cmd_t                 cmd,
  input  logic signed [VALUE_W-1:0] left_val,
  input  logic                      left_vld,
  input  logic signed [VALUE_W-1:0] right_val,
  input  logic                      right_vld,
  input  logic                      found_in,
  output logic                      found_out,
  output logic signed [VALUE_W-1:0] val,
  output logic                      vld,
  output logic signed [VALUE_W-1:0] tail_val
);

  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic                      vld_r, vld_nxt;
  logic                      match;
  logic                      is_tail;
  logic                      is_last;

  assign match     = vld_r && (val_r == cmd.key);
  assign found_out = found_in || match;
  assign is_tail   = !vld_r && left_vld;
  assign is_last   = vld_r && !right_vld;
  assign tail_val  = is_last ? val_r : '0;
  assign val       = val_r;
  assign vld       = vld_r;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (cmd.push_front) begin
      val_nxt = left_val;
      vld_nxt = left_vld;
    end else if (cmd.push_back) begin
      if (is_tail) begin
        val_nxt = cmd.key;
        vld_nxt = 1'b1;
      end
    end else if (cmd.pop_front || (cmd.del && found_out)) begin
      val_nxt = right_val;
      vld_nxt = right_vld;
    end else if (cmd.pop_back) begin
      if (is_last) begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

@@ design/bounded_deque_with_value_delete.sv @@
// Bounded deque of signed 32-bit values with delete of the first matching value.
// One command word is taken in every clock cycle (busy stays low) and its result
// word appears on out_word with out_strobe in the cycle after acceptance;
// the receiver must take it then. All commands, including delete, are done at
// once because every cell of the row compares and shifts in parallel; the
// first-match flag ripples combinationally through the row of DEPTH cells.
// depends on bdq_pkg and bdq_cell
module bounded_deque_with_value_delete
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              out_strobe_r;
  out_word_t         out_word_r, out_word_nxt;

  logic              accept;
  logic              full;
  logic              empty;
  cell_cmd_t         cmd;

  logic signed [VALUE_W-1:0] cell_val  [DEPTH];
  logic                      cell_vld  [DEPTH];
  logic signed [VALUE_W-1:0] cell_tail [DEPTH];
  logic [DEPTH:0]            found;
  logic signed [VALUE_W-1:0] back_val;
  logic [DEPTH-1:0]          vld_vec;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (fill_r == FILL_W'(DEPTH));
  assign empty  = (fill_r == '0);

  always_comb begin
    cmd            = '0;
    cmd.key        = in_word.value;
    cmd.push_front = accept && (in_word.kind == KIND_PUSH_FRONT) && !full;
    cmd.push_back  = accept && (in_word.kind == KIND_PUSH_BACK) && !full;
    cmd.pop_front  = accept && (in_word.kind == KIND_POP_FRONT) && !empty;
    cmd.pop_back   = accept && (in_word.kind == KIND_POP_BACK) && !empty;
    cmd.del        = accept && (in_word.kind == KIND_DELETE);
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] lv;
    logic                      lvl;
    logic signed [VALUE_W-1:0] rv;
    logic                      rvl;

    if (i == 0) begin : g_first
      assign lv  = in_word.value;
      assign lvl = 1'b1;
    end else begin : g_mid
      assign lv  = cell_val[i-1];
      assign lvl = cell_vld[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv  = '0;
      assign rvl = 1'b0;
    end else begin : g_inner
      assign rv  = cell_val[i+1];
      assign rvl = cell_vld[i+1];
    end

    bdq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_val  (lv),
      .left_vld  (lvl),
      .right_val (rv),
      .right_vld (rvl),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .val       (cell_val[i]),
      .vld       (cell_vld[i]),
      .tail_val  (cell_tail[i])
    );

    assign vld_vec[i] = cell_vld[i];
  end

  // one-hot or of the last occupied cell
  always_comb begin
    back_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_val = back_val | cell_tail[i];
    end
  end

  always_comb begin
    fill_nxt                   = fill_r;
    out_word_nxt               = '0;
    out_word_nxt.status        = ST_OK;
    case (in_word.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (full) begin
          out_word_nxt.status = ST_FULL;
        end else begin
          fill_nxt = fill_r + FILL_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          out_word_nxt.status = ST_EMPTY;
        end else begin
          fill_nxt                   = fill_r - FILL_W'(1);
          out_word_nxt.removed_value = cell_val[0];
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          out_word_nxt.status = ST_EMPTY;
        end else begin
          fill_nxt                   = fill_r - FILL_W'(1);
          out_word_nxt.removed_value = back_val;
        end
      end
      KIND_DELETE: begin
        if (empty) begin
          out_word_nxt.status = ST_EMPTY;
        end else if (found[DEPTH]) begin
          fill_nxt                   = fill_r - FILL_W'(1);
          out_word_nxt.removed_value = in_word.value;
        end else begin
          out_word_nxt.status = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
    out_word_nxt.count = COUNT_W'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
    if (!rst_n) begin
      fill_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= accept;
      if (accept) begin
        fill_r <= fill_nxt;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DEPTH))
    else $error("fill above depth");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(fill_r))
    else $error("cell occupancy disagrees with fill");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted word produced no result");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full && (in_word.kind == KIND_PUSH_FRONT || in_word.kind == KIND_PUSH_BACK))
    |=> (out_word.status == ST_FULL) && $stable(fill_r))
    else $error("push into full store changed state");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.status == ST_EMPTY) |-> (out_word.removed_value == '0))
    else $error("empty result carries a value");
`endif

endmodule
